FILE: rtl/dsos_pkg.sv
// Package: shared types and constants for the disk seek order scheduler.
`default_nettype none
package dsos_pkg;
    localparam int MAX_REQUESTS_DEF  = 32;
    localparam int CYLINDER_BITS_DEF = 16;
    localparam int IN_CYL_W          = 16;
    localparam int VALUE_W           = 22;
    localparam logic [VALUE_W-1:0] VALUE_MAX = 22'h3FFFFF;
    localparam int CFG_IDX_W         = 2;

    localparam logic [1:0] MODE_FCFS  = 2'd0;
    localparam logic [1:0] MODE_SCAN  = 2'd1;
    localparam logic [1:0] MODE_CSCAN = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_END  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEAD = 2'd2;

    localparam logic KIND_ENTRY = 1'b0;
    localparam logic KIND_TOTAL = 1'b1;

    typedef struct packed {
        logic [IN_CYL_W-1:0] request_cylinder;
        logic                last_request;
    } t_in;

    typedef struct packed {
        logic               item_kind;
        logic [VALUE_W-1:0] item_value;
        logic               last_item;
    } t_out;

    // Datapath commands from the controller.
    typedef struct packed {
        logic store_req;   // write incoming request at fill count
        logic clr_scan;    // start a scan pass: reset index, found flag
        logic rd_issue;    // read store at scan index
        logic scan_eval;   // evaluate read data against the chase key
        logic take_best;   // commit best as next key
        logic fcfs_acc;    // accumulate FCFS step for read data
        logic clr_batch;   // reset fill count, total
        logic [2:0] emit_sel; // what to present on output
    } t_cmd;

    typedef struct packed {
        logic scan_done;   // scan index reached fill count
        logic found;       // a candidate was found in last pass
        logic empty;       // fill count is zero
    } t_sts;

    localparam logic [2:0] EMIT_RD    = 3'd0;
    localparam logic [2:0] EMIT_BEST  = 3'd1;
    localparam logic [2:0] EMIT_ZERO  = 3'd2;
    localparam logic [2:0] EMIT_END   = 3'd3;
    localparam logic [2:0] EMIT_TOTAL = 3'd4;
endpackage
`default_nettype wire

FILE: rtl/disk_seek_order_scheduler.sv
// Top level: disk seek order scheduler.
// Channel | Direction | Handshake        | Payload
// in      | input     | valid / stall    | dsos_pkg::t_in
// out     | output    | valid / stall    | dsos_pkg::t_out
// cfg     | input     | valid / ready    | index, data
// Loading takes one request per cycle. After the last request, each sequence entry
// of SCAN or C-SCAN costs one pass over the N stored requests, read one at a time
// through the single read port of the request store; each group change adds an
// empty pass. FCFS emits each entry as it is read, then the total.
// Reset is synchronous and clears control; no item is taken while results drain.
`default_nettype none
module disk_seek_order_scheduler #(
    parameter int MAX_REQUESTS  = dsos_pkg::MAX_REQUESTS_DEF,
    parameter int CYLINDER_BITS = dsos_pkg::CYLINDER_BITS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    output logic                                   o_stall,
    input  wire dsos_pkg::t_in                     i_data,
    output logic                                   o_valid,
    input  wire logic                              i_stall,
    output dsos_pkg::t_out                         o_data,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [dsos_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [15:0]                       i_cfg_data
);
    logic [1:0]               r_mode;
    logic [CYLINDER_BITS-1:0] r_end, r_head;
    dsos_pkg::t_cmd cmd;
    dsos_pkg::t_sts sts;
    logic [1:0] phase;

    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= dsos_pkg::MODE_FCFS;
            r_end  <= CYLINDER_BITS'(65535);
            r_head <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                dsos_pkg::REG_MODE: r_mode <= i_cfg_data[1:0];
                dsos_pkg::REG_END:  r_end  <= CYLINDER_BITS'(i_cfg_data);
                dsos_pkg::REG_HEAD: r_head <= CYLINDER_BITS'(i_cfg_data);
                default: ;
            endcase
        end
    end

    dsos_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_mode      (r_mode),
        .i_in_valid  (i_valid),
        .i_last      (i_data.last_request),
        .i_out_stall (i_stall),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .o_phase     (phase),
        .o_in_stall  (o_stall),
        .o_out_valid (o_valid),
        .o_kind      (o_data.item_kind),
        .o_last      (o_data.last_item)
    );

    dsos_datapath #(.MAX_REQUESTS(MAX_REQUESTS), .CYLINDER_BITS(CYLINDER_BITS)) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_mode  (r_mode),
        .i_end   (r_end),
        .i_head  (r_head),
        .i_req   (CYLINDER_BITS'(i_data.request_cylinder)),
        .i_phase (phase),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .o_value (o_data.item_value)
    );
endmodule
`default_nettype wire

FILE: rtl/dsos_ram.sv
// Generic RAM with one write port and one registered read port.
`default_nettype none
module dsos_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

FILE: rtl/dsos_datapath.sv
// Datapath: request store, selection scan, total and output value.
`default_nettype none
module dsos_datapath #(
    parameter int MAX_REQUESTS  = dsos_pkg::MAX_REQUESTS_DEF,
    parameter int CYLINDER_BITS = dsos_pkg::CYLINDER_BITS_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic [1:0]                         i_mode,
    input  wire logic [CYLINDER_BITS-1:0]           i_end,
    input  wire logic [CYLINDER_BITS-1:0]           i_head,
    input  wire logic [CYLINDER_BITS-1:0]           i_req,
    input  wire logic [1:0]                         i_phase,
    input  wire dsos_pkg::t_cmd                     i_cmd,
    output dsos_pkg::t_sts                          o_sts,
    output logic [dsos_pkg::VALUE_W-1:0]            o_value
);
    localparam int AW = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
    localparam int CW = $clog2(MAX_REQUESTS + 1);
    localparam int KW = CYLINDER_BITS + CW;
    localparam int VW = dsos_pkg::VALUE_W;

    logic [CW-1:0] r_count, r_idx, r_eidx;
    logic [KW-1:0] r_key, r_best, cand;
    logic          r_found, r_keyv;
    logic [CYLINDER_BITS-1:0] rd, r_pos;
    logic [VW:0] r_total;
    logic [CYLINDER_BITS:0] diff;
    logic ok, better, store_we, in_group;
    logic [AW-1:0] raddr;

    assign store_we = i_cmd.store_req && (i_req < i_end)
                      && (r_count < CW'(MAX_REQUESTS));

    // Hold the read address while the read data is in use.
    assign raddr = i_cmd.rd_issue ? r_idx[AW-1:0] : r_eidx[AW-1:0];

    dsos_ram #(.WIDTH(CYLINDER_BITS), .DEPTH(MAX_REQUESTS)) u_store (
        .i_clk   (i_clk),
        .i_we    (store_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (i_req),
        .i_raddr (raddr),
        .o_rdata (rd)
    );

    // Phase 0: at head; 1: below head; 2: above head. Direction by mode/phase.
    always_comb begin
        unique case (i_phase)
            2'd0:    in_group = (rd == i_head);
            2'd1:    in_group = (rd < i_head);
            default: in_group = (rd > i_head);
        endcase
    end

    // Keys order by value, ties by arrival; SCAN below-head runs descending.
    logic desc;
    assign desc = (i_mode == dsos_pkg::MODE_SCAN) && (i_phase == 2'd1);
    always_comb begin
        if (desc) begin
            cand = {~rd, r_eidx};
        end else begin
            cand = {rd, r_eidx};
        end
    end
    assign ok = in_group && ((cand > r_key) || !r_keyv);
    assign better = !r_found || (cand < r_best);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_total <= '0;
            r_keyv  <= 1'b0;
            r_found <= 1'b0;
            r_idx   <= '0;
        end else begin
            if (store_we) begin
                r_count <= r_count + CW'(1);
            end
            if (i_cmd.store_req) begin
                r_pos <= i_head;
            end
            if (i_cmd.rd_issue) begin
                r_idx  <= r_idx + CW'(1);
                r_eidx <= r_idx;
            end
            if (i_cmd.clr_scan) begin
                r_idx   <= '0;
                r_found <= 1'b0;
            end
            if (i_cmd.scan_eval && ok && better) begin
                r_best  <= cand;
                r_found <= 1'b1;
            end
            if (i_cmd.take_best) begin
                r_key  <= r_best;
                r_keyv <= 1'b1;
            end
            if (i_cmd.fcfs_acc) begin
                r_total <= (r_total + (VW+1)'(diff) > (VW+1)'(dsos_pkg::VALUE_MAX))
                           ? (VW+1)'(dsos_pkg::VALUE_MAX) : r_total + (VW+1)'(diff);
                r_pos   <= rd;
            end
            if (i_cmd.clr_batch) begin
                r_count <= '0;
                r_total <= '0;
                r_keyv  <= 1'b0;
            end
            if (i_cmd.clr_scan && !r_found) begin
                r_keyv <= 1'b0;
            end
        end
    end

    assign diff = (rd > r_pos) ? {1'b0, rd - r_pos} : {1'b0, r_pos - rd};

    // Totals for SCAN and C-SCAN need max overall and max below head.
    logic [CYLINDER_BITS-1:0] r_max, r_maxlo;
    always_ff @(posedge i_clk) begin
        if (i_cmd.store_req) begin
            r_max   <= '0;
            r_maxlo <= '0;
        end else if (i_cmd.scan_eval && i_phase == 2'd0) begin
            if (rd > r_max) r_max <= rd;
            if (rd < i_head && rd > r_maxlo) r_maxlo <= rd;
        end
    end

    logic [VW:0] tot;
    always_comb begin
        case (i_mode)
            dsos_pkg::MODE_SCAN:  tot = (VW+1)'(i_head) + (VW+1)'(r_max);
            dsos_pkg::MODE_CSCAN: tot = ((i_end > i_head) ? (VW+1)'(i_end - i_head) : '0)
                                        + (VW+1)'(r_maxlo);
            default:              tot = r_total;
        endcase
    end

    always_comb begin
        case (i_cmd.emit_sel)
            dsos_pkg::EMIT_RD:    o_value = VW'(rd);
            dsos_pkg::EMIT_BEST:  o_value = desc ? VW'(CYLINDER_BITS'(~r_best[KW-1:CW]))
                                                 : VW'(r_best[KW-1:CW]);
            dsos_pkg::EMIT_END:   o_value = VW'(i_end);
            dsos_pkg::EMIT_TOTAL: o_value = (tot > (VW+1)'(dsos_pkg::VALUE_MAX))
                                            ? dsos_pkg::VALUE_MAX : tot[VW-1:0];
            default:              o_value = '0;
        endcase
    end

    assign o_sts.scan_done = (r_idx == r_count);
    assign o_sts.found     = r_found;
    assign o_sts.empty     = (r_count == '0);
endmodule
`default_nettype wire

FILE: rtl/dsos_ctrl.sv
// Controller: load, selection passes and result delivery.
`default_nettype none
module dsos_ctrl (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic [1:0]           i_mode,
    input  wire logic                 i_in_valid,
    input  wire logic                 i_last,
    input  wire logic                 i_out_stall,
    input  wire dsos_pkg::t_sts       i_sts,
    output dsos_pkg::t_cmd            o_cmd,
    output logic [1:0]                o_phase,
    output logic                      o_in_stall,
    output logic                      o_out_valid,
    output logic                      o_kind,
    output logic                      o_last
);
    localparam logic [2:0] S_LOAD  = 3'd0;
    localparam logic [2:0] S_RD    = 3'd1;
    localparam logic [2:0] S_WAIT  = 3'd2;
    localparam logic [2:0] S_EVAL  = 3'd3;
    localparam logic [2:0] S_EMIT  = 3'd4;
    localparam logic [2:0] S_FIX   = 3'd5;
    localparam logic [2:0] S_TOT   = 3'd6;

    logic [2:0] r_state, n_state;
    logic [1:0] r_phase, n_phase;
    logic [1:0] r_fix, n_fix;   // fixed entries still to emit
    logic       fcfs, in_acc;

    assign fcfs    = !(i_mode == dsos_pkg::MODE_SCAN || i_mode == dsos_pkg::MODE_CSCAN);
    assign o_phase = r_phase;
    assign o_in_stall = (r_state != S_LOAD);
    assign in_acc  = i_in_valid && (r_state == S_LOAD);

    // Phase sequence: 0 at head, then SCAN: 1,fix,2; C-SCAN: 2,fix,1.
    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        n_fix   = r_fix;
        o_cmd   = '0;
        o_cmd.emit_sel = dsos_pkg::EMIT_BEST;
        o_out_valid = 1'b0;
        o_kind = dsos_pkg::KIND_ENTRY;
        o_last = 1'b0;
        unique case (r_state)
            S_LOAD: begin
                o_cmd.store_req = in_acc;
                if (in_acc && i_last) begin
                    n_state = S_RD;
                    n_phase = 2'd0;
                    o_cmd.clr_scan = 1'b1;
                end
            end
            S_RD: begin
                if (i_sts.scan_done) begin
                    n_state = S_EVAL;
                end else begin
                    o_cmd.rd_issue = 1'b1;
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                if (fcfs) begin
                    o_cmd.emit_sel = dsos_pkg::EMIT_RD;
                    o_out_valid = 1'b1;
                    if (!i_out_stall) begin
                        o_cmd.fcfs_acc = 1'b1;
                        n_state = S_RD;
                    end
                end else begin
                    o_cmd.scan_eval = 1'b1;
                    n_state = S_RD;
                end
            end
            S_EVAL: begin
                if (fcfs) begin
                    n_state = S_TOT;
                end else if (i_sts.found) begin
                    o_cmd.take_best = 1'b1;
                    n_state = S_EMIT;
                end else begin
                    // group exhausted: next phase, fixed entries or total
                    o_cmd.clr_scan = 1'b1;
                    o_cmd.emit_sel = dsos_pkg::EMIT_END;
                    n_state = S_RD;
                    if (r_phase == 2'd0) begin
                        n_phase = (i_mode == dsos_pkg::MODE_SCAN) ? 2'd1 : 2'd2;
                    end else if (r_fix == 2'd0) begin
                        n_fix = (i_mode == dsos_pkg::MODE_SCAN) ? 2'd1 : 2'd2;
                        n_state = S_FIX;
                    end else begin
                        n_state = S_TOT;
                    end
                end
            end
            S_EMIT: begin
                o_out_valid = 1'b1;
                if (!i_out_stall) begin
                    o_cmd.clr_scan = 1'b1;
                    n_state = S_RD;
                end
            end
            S_FIX: begin
                o_out_valid = 1'b1;
                o_cmd.emit_sel = (r_fix == 2'd2) ? dsos_pkg::EMIT_END : dsos_pkg::EMIT_ZERO;
                if (!i_out_stall) begin
                    if (r_fix == 2'd1 || r_fix == 2'd3) begin
                        n_fix = 2'd3;
                        n_phase = (r_phase == 2'd1) ? 2'd2 : 2'd1;
                        o_cmd.clr_scan = 1'b1;
                        n_state = S_RD;
                    end else begin
                        n_fix = 2'd1;
                    end
                end
            end
            default: begin
                o_out_valid = 1'b1;
                o_kind = dsos_pkg::KIND_TOTAL;
                o_last = 1'b1;
                o_cmd.emit_sel = dsos_pkg::EMIT_TOTAL;
                if (!i_out_stall) begin
                    o_cmd.clr_batch = 1'b1;
                    n_state = S_LOAD;
                    n_fix = 2'd0;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_phase <= 2'd0;
            r_fix   <= 2'd0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_fix   <= n_fix;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last |-> o_out_valid && o_kind == dsos_pkg::KIND_TOTAL)
        else $error("last without total");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("output while loading");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("result dropped under stall");
endmodule
`default_nettype wire

FILE: verif/disk_seek_order_scheduler_tb.sv
// Testbench for the disk seek order scheduler: directed and random batches.
`timescale 1ns / 100ps
`default_nettype none
module disk_seek_order_scheduler_tb;
    localparam int MAX_REQ   = 32;
    localparam int WDOG_MAX  = 100000;
    localparam int DRAIN_CYC = 200;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    dsos_pkg::t_in  i_data = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    dsos_pkg::t_out o_data;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [dsos_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;

    logic [1:0]  sched_mode = dsos_pkg::MODE_FCFS;
    logic [15:0] end_cyl = 16'hFFFF;
    logic [15:0] head_cyl = 16'd0;
    logic [15:0] batch_q[$];
    dsos_pkg::t_out expected_q[$];

    int mismatches = 0;
    int idle_cycles = 0;
    int stall_left = 0;
    bit long_stalls = 1'b1;

    disk_seek_order_scheduler uut (.*);

    always #1 i_clk = ~i_clk;

    function automatic int gap_len();
        if ($urandom_range(0, 3) == 0) return 0;
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
        return $urandom_range(0, 3);
    endfunction

    task automatic push_entry(input logic [21:0] v);
        dsos_pkg::t_out e;
        e.item_kind = dsos_pkg::KIND_ENTRY;
        e.item_value = v;
        e.last_item = 1'b0;
        expected_q.push_back(e);
    endtask

    task automatic predict_schedule();
        logic [15:0] lo[$];
        logic [15:0] hi[$];
        logic [15:0] big;
        logic [15:0] pos;
        longint total;
        dsos_pkg::t_out e;
        total = 0;
        big = 0;
        if (sched_mode == dsos_pkg::MODE_SCAN || sched_mode == dsos_pkg::MODE_CSCAN) begin
            foreach (batch_q[i]) begin
                if (batch_q[i] > big) big = batch_q[i];
                if (batch_q[i] == head_cyl) push_entry(22'(batch_q[i]));
                else if (batch_q[i] < head_cyl) lo.push_back(batch_q[i]);
                else hi.push_back(batch_q[i]);
            end
            lo.sort();
            hi.sort();
            if (sched_mode == dsos_pkg::MODE_SCAN) begin
                for (int i = lo.size() - 1; i >= 0; i--) push_entry(22'(lo[i]));
                push_entry(22'd0);
                foreach (hi[i]) push_entry(22'(hi[i]));
                total = longint'(head_cyl) + longint'(big);
            end else begin
                foreach (hi[i]) push_entry(22'(hi[i]));
                push_entry(22'(end_cyl));
                push_entry(22'd0);
                foreach (lo[i]) push_entry(22'(lo[i]));
                total = (end_cyl > head_cyl) ? longint'(end_cyl - head_cyl) : 0;
                if (lo.size() > 0) total += longint'(lo[lo.size() - 1]);
            end
        end else begin
            pos = head_cyl;
            foreach (batch_q[i]) begin
                total += (batch_q[i] > pos) ? longint'(batch_q[i] - pos)
                                            : longint'(pos - batch_q[i]);
                pos = batch_q[i];
                push_entry(22'(batch_q[i]));
            end
        end
        e.item_kind = dsos_pkg::KIND_TOTAL;
        e.item_value = (total > longint'(dsos_pkg::VALUE_MAX)) ? dsos_pkg::VALUE_MAX
                                                               : total[21:0];
        e.last_item = 1'b1;
        expected_q.push_back(e);
        batch_q.delete();
    endtask

    task automatic send_request(input logic [15:0] cyl, input logic last);
        int gap;
        gap = gap_len();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data.request_cylinder <= cyl;
        i_data.last_request <= last;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        if (cyl < end_cyl && batch_q.size() < MAX_REQ) batch_q.push_back(cyl);
        if (last) begin
            predict_schedule();
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    task automatic wait_idle();
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [dsos_pkg::CFG_IDX_W-1:0] idx,
                             input logic [15:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            dsos_pkg::REG_MODE: sched_mode = val[1:0];
            dsos_pkg::REG_END:  end_cyl = val;
            dsos_pkg::REG_HEAD: head_cyl = val;
            default: ;
        endcase
    endtask

    task automatic configure(input logic [1:0] m, input logic [15:0] e,
                             input logic [15:0] h);
        wait_idle();
        write_reg(dsos_pkg::REG_MODE, {14'd0, m});
        write_reg(dsos_pkg::REG_END, e);
        write_reg(dsos_pkg::REG_HEAD, h);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_batch(input int n, input logic [15:0] span);
        for (int i = 0; i < n; i++) begin
            send_request(16'($urandom_range(0, int'(span))), i == n - 1);
        end
    endtask

    task automatic test_fcfs_directed();
        configure(dsos_pkg::MODE_FCFS, 16'hFFFF, 16'd0);
        send_request(16'hFFFE, 1'b0);
        send_request(16'd0, 1'b0);
        send_request(16'hFFFF, 1'b0);
        send_request(16'h5555, 1'b1);
        send_request(16'd7, 1'b1);
    endtask

    task automatic test_scan_directed();
        configure(dsos_pkg::MODE_SCAN, 16'd1000, 16'd500);
        send_request(16'd500, 1'b0);
        send_request(16'd200, 1'b0);
        send_request(16'd800, 1'b0);
        send_request(16'd200, 1'b0);
        send_request(16'd1000, 1'b0);
        send_request(16'd999, 1'b1);
        send_request(16'd1500, 1'b1);
    endtask

    task automatic test_cscan_directed();
        configure(dsos_pkg::MODE_CSCAN, 16'd1, 16'd0);
        send_request(16'd0, 1'b0);
        send_request(16'd1, 1'b1);
        configure(dsos_pkg::MODE_CSCAN, 16'd100, 16'd200);
        send_request(16'd50, 1'b0);
        send_request(16'd10, 1'b1);
        configure(2'd3, 16'hFFFF, 16'hFFFE);
        send_request(16'd0, 1'b0);
        send_request(16'hFFFE, 1'b1);
    endtask

    task automatic test_full_store();
        configure(dsos_pkg::MODE_FCFS, 16'hFFFF, 16'hFFFE);
        for (int i = 0; i < 34; i++) send_request(i[0] ? 16'd0 : 16'hFFFE, i == 33);
    endtask

    task automatic test_random();
        int sent;
        int n;
        logic [15:0] e;
        sent = 0;
        while (sent < 270) begin
            e = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(1, 64))
                                            : 16'($urandom_range(1, 16'hFFFF));
            configure(2'($urandom_range(0, 3)), e, 16'($urandom_range(0, int'(e) - 1)));
            long_stalls = 1'($urandom_range(0, 1));
            repeat (3) begin
                n = ($urandom_range(0, 9) == 0) ? int'($urandom_range(30, 36))
                                                : int'($urandom_range(1, 8));
                send_batch(n, ($urandom_range(0, 4) == 0) ? 16'hFFFF : e);
                sent += n;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            i_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end else if (long_stalls && $urandom_range(0, 49) == 0) begin
            i_stall <= 1'b1;
            stall_left <= int'($urandom_range(10, 40));
        end else begin
            i_stall <= ($urandom_range(0, 3) == 0);
        end
    end

    always @(posedge i_clk) begin
        dsos_pkg::t_out e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", o_data);
            end else begin
                e = expected_q.pop_front();
                if (o_data !== e) begin
                    mismatches++;
                    if (mismatches <= 10) $display("expected %p got %p", e, o_data);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready)
                || !i_rst_n) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WDOG_MAX) begin
            $display("tb: failure");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_fcfs_directed();
        test_scan_directed();
        test_cscan_directed();
        test_full_store();
        test_random();
        wait_idle();
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
`default_nettype wire

FILE: sim.f
rtl/dsos_pkg.sv
rtl/dsos_ram.sv
rtl/dsos_datapath.sv
rtl/dsos_ctrl.sv
rtl/disk_seek_order_scheduler.sv
verif/disk_seek_order_scheduler_tb.sv
